FILE: hdl/oneshot_periodic_timer_table_macros.svh
// Assertion macros for the timer table.
`ifndef ONESHOT_PERIODIC_TIMER_TABLE_MACROS_SVH
`define ONESHOT_PERIODIC_TIMER_TABLE_MACROS_SVH
// Same-cycle implication, disabled while reset is low.
`define OPT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("timer table check failed");
// Next-cycle implication, disabled while reset is low.
`define OPT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("timer table check failed");
`endif

FILE: hdl/opt_pkg.sv
// Shared constants, types and helpers of the timer table.
`timescale 1ns / 1ps
package opt_pkg;
    localparam int SLOTS    = 16;
    localparam int IDX_W    = $clog2(SLOTS);
    localparam int TIME_W   = 32;
    localparam int TGT_W    = 16;
    localparam int HANDLE_W = 32;
    localparam int COUNT_W  = 5;
    localparam int IN_W     = 120;
    localparam int OUT_W    = 56;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_ADD    = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_FIRED  = 2'd2,
        KIND_EMPTY  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_RM_SCAN,
        ST_RM_DONE,
        ST_DUE_SCAN,
        ST_SRCH,
        ST_PICK
    } t_state;

    typedef struct packed {
        logic ready;
        logic load;
        logic add_do;
        logic rm_scan;
        logic rm_done;
        logic due_scan;
        logic srch_scan;
        logic pass_set;
        logic fire;
        logic final_emit;
    } t_dp_ctl;

    typedef struct packed {
        logic idx_last;
        logic out_free;
        logic found;
        logic have_pend;
        logic pass;
    } t_dp_sts;

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction
endpackage

FILE: hdl/opt_ctrl.sv
// Controller state machine of the timer table.
`timescale 1ns / 1ps
module opt_ctrl import opt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_cmd    i_in_cmd,
    input  t_dp_sts i_sts,
    output t_dp_ctl o_ctl
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_ctl.ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.load = 1'b1;
                    unique case (i_in_cmd)
                        CMD_TICK:   n_state = ST_DUE_SCAN;
                        CMD_ADD:    n_state = ST_ADD;
                        CMD_REMOVE: n_state = ST_RM_SCAN;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_ADD: begin
                if (i_sts.out_free) begin
                    o_ctl.add_do = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            ST_RM_SCAN: begin
                o_ctl.rm_scan = 1'b1;
                if (i_sts.idx_last) n_state = ST_RM_DONE;
            end
            ST_RM_DONE: begin
                if (i_sts.out_free) begin
                    o_ctl.rm_done = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            ST_DUE_SCAN: begin
                o_ctl.due_scan = 1'b1;
                if (i_sts.idx_last) n_state = ST_SRCH;
            end
            ST_SRCH: begin
                o_ctl.srch_scan = 1'b1;
                if (i_sts.idx_last) n_state = ST_PICK;
            end
            ST_PICK: begin
                if (i_sts.found) begin
                    if (!i_sts.have_pend || i_sts.out_free) begin
                        o_ctl.fire = 1'b1;
                        n_state    = ST_SRCH;
                    end
                end else if (!i_sts.pass) begin
                    o_ctl.pass_set = 1'b1;
                    n_state        = ST_SRCH;
                end else if (i_sts.out_free) begin
                    o_ctl.final_emit = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

FILE: hdl/opt_dp.sv
// Datapath of the timer table: slot storage, scan unit and result register.
`timescale 1ns / 1ps
module opt_dp import opt_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_ctl             i_ctl,
    input  logic [IN_W-1:0]     i_tdata,
    input  logic                i_out_ready,
    output t_dp_sts             o_sts,
    output logic                o_out_valid,
    output logic [OUT_W-1:0]    o_out_data,
    output t_kind               o_out_kind,
    output logic                o_out_last
);
    // slot storage
    logic [SLOTS-1:0]    r_valid;
    logic [SLOTS-1:0]    r_due_flag;
    logic                r_per  [SLOTS];
    logic [HANDLE_W-1:0] r_hdl  [SLOTS];
    logic [TGT_W-1:0]    r_tgt  [SLOTS];
    logic [TIME_W-1:0]   r_due  [SLOTS];
    logic [TIME_W-1:0]   r_int  [SLOTS];
    logic [HANDLE_W-1:0] r_hcnt;

    // latched item
    logic [TIME_W-1:0]   r_now;
    logic [TGT_W-1:0]    r_in_tgt;
    logic                r_in_per;
    logic [TIME_W-1:0]   r_in_dly;
    logic [HANDLE_W-1:0] r_in_rmh;

    // scan and selection
    logic [IDX_W-1:0]    r_idx;
    logic                r_found;
    logic [IDX_W-1:0]    r_b_idx;
    logic [HANDLE_W-1:0] r_b_hdl;
    logic [TGT_W-1:0]    r_b_tgt;
    logic [TIME_W-1:0]   r_b_int;
    logic                r_pass;
    logic                r_have_pend;
    logic [HANDLE_W-1:0] r_p_hdl;
    logic [TGT_W-1:0]    r_p_tgt;
    logic [COUNT_W-1:0]  r_cnt;

    // result register
    logic                r_ovalid;
    logic [HANDLE_W-1:0] r_o_hdl;
    logic [TGT_W-1:0]    r_o_tgt;
    logic                r_o_ok;
    logic [COUNT_W-1:0]  r_o_cnt;
    t_kind               r_o_kind;
    logic                r_o_last;

    logic                idx_last;
    logic                full;
    logic [IDX_W-1:0]    free_idx;
    logic                rm_hit;
    logic                srch_hit;
    logic                add_ok;
    logic                o_load;

    assign idx_last = (r_idx == IDX_W'(SLOTS - 1));
    assign full     = &r_valid;

    always_comb begin
        free_idx = '0;
        for (int k = SLOTS - 1; k >= 0; k--) begin
            if (!r_valid[k]) free_idx = IDX_W'(k);
        end
    end

    assign rm_hit   = r_valid[r_idx] && (r_hdl[r_idx] == r_in_rmh) && !r_found;
    assign srch_hit = r_due_flag[r_idx] && (r_per[r_idx] == r_pass) &&
                      (!r_found || (r_hdl[r_idx] < r_b_hdl));
    assign add_ok   = (r_in_tgt != '0) && !full;
    assign o_load   = i_ctl.add_do || i_ctl.rm_done || i_ctl.final_emit ||
                      (i_ctl.fire && r_have_pend);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_due_flag  <= '0;
            r_hcnt      <= HANDLE_W'(1);
            r_idx       <= '0;
            r_found     <= 1'b0;
            r_pass      <= 1'b0;
            r_have_pend <= 1'b0;
            r_cnt       <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            if (i_ctl.load) begin
                r_idx       <= '0;
                r_found     <= 1'b0;
                r_pass      <= 1'b0;
                r_have_pend <= 1'b0;
                r_cnt       <= '0;
            end
            if (i_ctl.rm_scan || i_ctl.due_scan || i_ctl.srch_scan) begin
                r_idx <= idx_last ? '0 : r_idx + IDX_W'(1);
            end
            if (i_ctl.due_scan) begin
                r_due_flag[r_idx] <= r_valid[r_idx] && (r_now > r_due[r_idx]);
            end
            if ((i_ctl.rm_scan && rm_hit) || (i_ctl.srch_scan && srch_hit)) begin
                r_found <= 1'b1;
            end
            if (i_ctl.add_do && add_ok) begin
                r_valid[free_idx] <= 1'b1;
                r_hcnt <= (r_hcnt == '1) ? HANDLE_W'(1) : r_hcnt + HANDLE_W'(1);
            end
            if (i_ctl.rm_done && r_found) r_valid[r_b_idx] <= 1'b0;
            if (i_ctl.pass_set) r_pass <= 1'b1;
            if (i_ctl.fire) begin
                r_found             <= 1'b0;
                r_have_pend         <= 1'b1;
                r_cnt               <= r_cnt + COUNT_W'(1);
                r_due_flag[r_b_idx] <= 1'b0;
                if (!r_pass) r_valid[r_b_idx] <= 1'b0;
            end
            if (o_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_now    <= i_tdata[31:0];
            r_in_tgt <= i_tdata[47:32];
            r_in_per <= i_tdata[48];
            r_in_dly <= i_tdata[80:49];
            r_in_rmh <= i_tdata[112:81];
        end
        if ((i_ctl.rm_scan && rm_hit) || (i_ctl.srch_scan && srch_hit)) begin
            r_b_idx <= r_idx;
            r_b_hdl <= r_hdl[r_idx];
            r_b_tgt <= r_tgt[r_idx];
            r_b_int <= r_int[r_idx];
        end
        if (i_ctl.add_do && add_ok) begin
            r_per[free_idx] <= r_in_per;
            r_hdl[free_idx] <= r_hcnt;
            r_tgt[free_idx] <= r_in_tgt;
            r_int[free_idx] <= r_in_dly;
            r_due[free_idx] <= sat_add(r_now, r_in_dly);
        end
        if (i_ctl.fire) begin
            r_p_hdl <= r_b_hdl;
            r_p_tgt <= r_b_tgt;
            if (r_pass) r_due[r_b_idx] <= sat_add(r_now, r_b_int);
        end
        if (i_ctl.add_do) begin
            r_o_kind <= KIND_ADD;
            r_o_hdl  <= add_ok ? r_hcnt : '0;
            r_o_tgt  <= '0;
            r_o_ok   <= add_ok;
            r_o_cnt  <= '0;
            r_o_last <= 1'b1;
        end else if (i_ctl.rm_done) begin
            r_o_kind <= KIND_REMOVE;
            r_o_hdl  <= '0;
            r_o_tgt  <= r_found ? r_b_tgt : '0;
            r_o_ok   <= r_found;
            r_o_cnt  <= '0;
            r_o_last <= 1'b1;
        end else if (i_ctl.fire && r_have_pend) begin
            // first fire only parks its timer; the result register may still hold
            // the previous item's beat
            r_o_kind <= KIND_FIRED;
            r_o_hdl  <= r_p_hdl;
            r_o_tgt  <= r_p_tgt;
            r_o_ok   <= 1'b0;
            r_o_cnt  <= '0;
            r_o_last <= 1'b0;
        end else if (i_ctl.final_emit) begin
            r_o_kind <= r_have_pend ? KIND_FIRED : KIND_EMPTY;
            r_o_hdl  <= r_have_pend ? r_p_hdl : '0;
            r_o_tgt  <= r_have_pend ? r_p_tgt : '0;
            r_o_ok   <= 1'b0;
            r_o_cnt  <= r_have_pend ? r_cnt : '0;
            r_o_last <= 1'b1;
        end
    end

    assign o_sts.idx_last  = idx_last;
    assign o_sts.out_free  = !r_ovalid || i_out_ready;
    assign o_sts.found     = r_found;
    assign o_sts.have_pend = r_have_pend;
    assign o_sts.pass      = r_pass;

    assign o_out_valid = r_ovalid;
    assign o_out_data  = {2'b00, r_o_cnt, r_o_ok, r_o_tgt, r_o_hdl};
    assign o_out_kind  = r_o_kind;
    assign o_out_last  = r_o_last;
endmodule

FILE: hdl/oneshot_periodic_timer_table.sv
// Top level of the one-shot and periodic timer table.
// Throughput: one item at a time; the next beat is taken once the last result is queued.
// The 16-slot scan unit reads one slot per cycle.
// Reset (i_rst_n low, synchronous): table empty, handle counter at 1, no result pending.
`timescale 1ns / 1ps
`include "oneshot_periodic_timer_table_macros.svh"
module oneshot_periodic_timer_table import opt_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // tdata: now_ticks[31:0], target_id[47:32], periodic[48], delay_ticks[80:49],
    //        remove_handle[112:81], zero fill
    input  logic [IN_W-1:0]  i_s_axis_tdata,
    // tuser: cmd
    input  logic [1:0]       i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    // tdata: out_handle[31:0], out_target[47:32], ok[48], fired_count[53:49], zero fill
    output logic [OUT_W-1:0] o_m_axis_tdata,
    // tuser: kind
    output logic [1:0]       o_m_axis_tuser,
    output logic             o_m_axis_tlast
);
    t_dp_ctl ctl;
    t_dp_sts sts;
    t_kind   out_kind;

    // Controller sequences the scans; the datapath holds the slots and the
    // result register, so a finished beat waits there while scanning goes on.
    // Tick: a scan flags due slots, then each pass (one-shots first) runs a 16-slot
    // search and a pick per fired timer, plus one to end it; output stalls hold the pick.
    opt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_in_cmd   (t_cmd'(i_s_axis_tuser)),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    opt_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_tdata     (i_s_axis_tdata),
        .i_out_ready (i_m_axis_tready),
        .o_sts       (sts),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata),
        .o_out_kind  (out_kind),
        .o_out_last  (o_m_axis_tlast)
    );

    assign o_s_axis_tready = ctl.ready;
    assign o_m_axis_tuser  = out_kind;

    // A taken beat other than CMD_NONE leaves the block busy in the following cycle.
    `OPT_ASSERT_NXT(a_busy_after_take, i_clk, i_rst_n,
        i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tuser != CMD_NONE),
        !o_s_axis_tready)
    // An empty tick result carries nothing but its kind and last flag.
    `OPT_ASSERT_NOW(a_empty_zero, i_clk, i_rst_n,
        o_m_axis_tvalid && (o_m_axis_tuser == KIND_EMPTY),
        (o_m_axis_tdata == '0) && o_m_axis_tlast)
    // An accepted add never hands out handle zero.
    `OPT_ASSERT_NOW(a_add_handle, i_clk, i_rst_n,
        o_m_axis_tvalid && (o_m_axis_tuser == KIND_ADD) && o_m_axis_tdata[48],
        o_m_axis_tdata[31:0] != '0)
    // Only the closing fired beat carries a count.
    `OPT_ASSERT_NOW(a_fired_count, i_clk, i_rst_n,
        o_m_axis_tvalid && (o_m_axis_tuser == KIND_FIRED) && !o_m_axis_tlast,
        o_m_axis_tdata[53:49] == '0)
endmodule

FILE: verif/oneshot_periodic_timer_table_tb.sv
// Self-checking testbench of the one-shot and periodic timer table.
`timescale 1ns / 1ps
module oneshot_periodic_timer_table_tb;
    import opt_pkg::*;

    logic             i_clk;
    logic             i_rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic [1:0]       s_tuser;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;
    logic [1:0]       m_tuser;
    logic             m_tlast;

    oneshot_periodic_timer_table u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    typedef struct {
        t_cmd                cmd;
        logic [TIME_W-1:0]   now;
        logic [TGT_W-1:0]    target;
        logic                periodic;
        logic [TIME_W-1:0]   delay;
        logic [HANDLE_W-1:0] handle;
    } t_req;

    typedef struct {
        t_kind               kind;
        logic [HANDLE_W-1:0] handle;
        logic [TGT_W-1:0]    target;
        logic                ok;
        logic [COUNT_W-1:0]  count;
        logic                last;
    } t_reply;

    // directed table row: request plus optional hand-typed first reply
    typedef struct {
        t_req   req;
        logic   typed;
        t_reply rep;
    } t_row;

    // shadow timer table
    logic                tt_valid    [SLOTS];
    logic                tt_periodic [SLOTS];
    logic [HANDLE_W-1:0] tt_handle   [SLOTS];
    logic [TGT_W-1:0]    tt_target   [SLOTS];
    logic [TIME_W-1:0]   tt_due      [SLOTS];
    logic [TIME_W-1:0]   tt_interval [SLOTS];
    logic [HANDLE_W-1:0] next_handle;
    logic [HANDLE_W-1:0] issued [$];  // handles handed out, for remove stimulus

    t_reply pending_replies [$];
    int     errors;
    int     n_sent, n_replies, n_fired;
    int     src_idle, snk_idle;

    function automatic logic [TIME_W-1:0] due_sum(logic [TIME_W-1:0] a,
                                                 logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? '1 : s[TIME_W-1:0];
    endfunction

    function automatic t_reply mk(t_kind k, logic [HANDLE_W-1:0] h, logic [TGT_W-1:0] t,
                                  logic ok, logic [COUNT_W-1:0] c, logic l);
        t_reply r;
        r.kind = k; r.handle = h; r.target = t; r.ok = ok; r.count = c; r.last = l;
        return r;
    endfunction

    function automatic bit same_reply(t_reply a, t_reply b);
        return (a.kind == b.kind) && (a.handle == b.handle) && (a.target == b.target) &&
               (a.ok == b.ok) && (a.count == b.count) && (a.last == b.last);
    endfunction

    // Predict the replies of one request and advance the shadow table.
    task automatic predict_timer_table(input t_req q);
        int  free_i, best, n;
        bit  due [SLOTS];
        bit  found;
        t_reply fired [$];
        free_i = -1;
        case (q.cmd)
            CMD_ADD: begin
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (!tt_valid[i]) free_i = i;
                if (q.target == 0 || free_i < 0) begin
                    pending_replies.insert(pending_replies.size(), mk(KIND_ADD, 0, 0, 0, 0, 1));
                end else begin
                    tt_valid[free_i]    = 1;
                    tt_periodic[free_i] = q.periodic;
                    tt_handle[free_i]   = next_handle;
                    tt_target[free_i]   = q.target;
                    tt_interval[free_i] = q.delay;
                    tt_due[free_i]      = due_sum(q.now, q.delay);
                    pending_replies.insert(pending_replies.size(),
                                           mk(KIND_ADD, next_handle, 0, 1, 0, 1));
                    issued.insert(issued.size(), next_handle);
                    // counter skips zero on wrap
                    next_handle = (next_handle == '1) ? 1 : next_handle + 1;
                end
            end
            CMD_REMOVE: begin
                found = 0;
                for (int i = 0; i < SLOTS; i++)
                    if (!found && tt_valid[i] && tt_handle[i] == q.handle) begin
                        found = 1;
                        tt_valid[i] = 0;
                        pending_replies.insert(pending_replies.size(),
                                               mk(KIND_REMOVE, 0, tt_target[i], 1, 0, 1));
                    end
                if (!found)
                    pending_replies.insert(pending_replies.size(),
                                           mk(KIND_REMOVE, 0, 0, 0, 0, 1));
            end
            CMD_TICK: begin
                for (int i = 0; i < SLOTS; i++) due[i] = tt_valid[i] && (q.now > tt_due[i]);
                // one-shots first, then periodics; lowest handle first, ties by slot
                for (int pass = 0; pass < 2; pass++) begin
                    forever begin
                        best = -1;
                        for (int i = 0; i < SLOTS; i++)
                            if (due[i] && int'(tt_periodic[i]) == pass &&
                                (best < 0 || tt_handle[i] < tt_handle[best]))
                                best = i;
                        if (best < 0) break;
                        due[best] = 0;
                        fired.insert(fired.size(),
                                     mk(KIND_FIRED, tt_handle[best], tt_target[best], 0, 0, 0));
                        if (pass == 0) tt_valid[best] = 0;
                        else tt_due[best] = due_sum(q.now, tt_interval[best]);
                    end
                end
                n = fired.size();
                if (n == 0) begin
                    pending_replies.insert(pending_replies.size(), mk(KIND_EMPTY, 0, 0, 0, 0, 1));
                end else begin
                    fired[n-1].count = n[COUNT_W-1:0];
                    fired[n-1].last  = 1;
                    foreach (fired[i]) pending_replies.insert(pending_replies.size(), fired[i]);
                    n_fired += n;
                end
            end
            default: ;  // ignored command: no reply
        endcase
    endtask

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("oneshot_periodic_timer_table_tb failed");
        $finish;
    end

    // receiver: random stall, compare each beat with the oldest expectation
    always @(negedge i_clk)
        m_tready <= ($urandom_range(99) >= snk_idle);

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            t_reply e;
            n_replies++;
            if (pending_replies.size() == 0) begin
                $error("unexpected beat kind=%0d handle=%0h", m_tuser, m_tdata[31:0]);
                errors++;
            end else begin
                e = pending_replies.pop_front();
                if (m_tuser !== e.kind) begin
                    $error("kind exp %0d got %0d", e.kind, m_tuser); errors++;
                end
                if (m_tdata[31:0] !== e.handle) begin
                    $error("out_handle exp %0h got %0h", e.handle, m_tdata[31:0]); errors++;
                end
                if (m_tdata[47:32] !== e.target) begin
                    $error("out_target exp %0h got %0h", e.target, m_tdata[47:32]); errors++;
                end
                if (m_tdata[48] !== e.ok) begin
                    $error("ok exp %0d got %0d", e.ok, m_tdata[48]); errors++;
                end
                if (m_tdata[53:49] !== e.count) begin
                    $error("fired_count exp %0d got %0d", e.count, m_tdata[53:49]); errors++;
                end
                if (m_tlast !== e.last) begin
                    $error("last exp %0d got %0d", e.last, m_tlast); errors++;
                end
            end
        end
    end

    // Drive one request beat at a falling edge, hold until accepted; returns
    // at the accepting rising edge with tvalid still high.
    task automatic send_request(input t_req q);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 0;
            @(negedge i_clk);
        end
        s_tvalid <= 1;
        s_tuser  <= q.cmd;
        s_tdata  <= {7'd0, q.handle, q.delay, q.periodic, q.target, q.now};
        predict_timer_table(q);
        n_sent++;
        do @(posedge i_clk); while (!s_tready);
    endtask

    // Drop tvalid and hold off until every expected beat has come.
    task automatic wait_drain();
        @(negedge i_clk);
        s_tvalid <= 0;
        while (pending_replies.size() != 0) @(negedge i_clk);
    endtask

    function automatic t_req rq(t_cmd c, logic [TIME_W-1:0] now, logic [TGT_W-1:0] t,
                                logic p, logic [TIME_W-1:0] d, logic [HANDLE_W-1:0] h);
        t_req q;
        q.cmd = c; q.now = now; q.target = t; q.periodic = p; q.delay = d; q.handle = h;
        return q;
    endfunction

    function automatic t_req rand_req(logic [TIME_W-1:0] clock_now);
        t_req q;
        int   sel;
        sel = $urandom_range(99);
        q = rq(CMD_TICK, clock_now, TGT_W'($urandom), 1'($urandom),
               TIME_W'($urandom_range(200)), HANDLE_W'($urandom));
        if (sel < 40) begin
            q.cmd = CMD_ADD;
            if ($urandom_range(9) == 0) q.target = '0;
            if ($urandom_range(9) == 0) q.delay = $urandom;   // wide delays, saturation
            if ($urandom_range(19) == 0) q.now = $urandom;
        end else if (sel < 55) begin
            q.cmd = CMD_REMOVE;
            if (issued.size() != 0 && $urandom_range(3) != 0)
                q.handle = issued[$urandom_range(issued.size() - 1)];
        end else if (sel < 58) begin
            q.cmd = CMD_NONE;
        end else if ($urandom_range(29) == 0) begin
            q.now = $urandom;
        end
        return q;
    endfunction

    t_row   rows [$];
    t_reply first_rep;
    logic [TIME_W-1:0] clock_now;
    int     n_rand;

    initial begin
        errors = 0; n_sent = 0; n_replies = 0; n_fired = 0;
        src_idle = 0; snk_idle = 0;
        i_rst_n = 0; s_tvalid = 0; s_tdata = '0; s_tuser = CMD_TICK; m_tready = 0;
        foreach (tt_valid[i]) tt_valid[i] = 0;
        next_handle = 1;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed: reset state, refusals, saturation, full table, order, removes
        rows.insert(rows.size(), '{rq(CMD_TICK, '1, 0, 0, 0, 0), 1,
                                   mk(KIND_EMPTY, 0, 0, 0, 0, 1)});
        rows.insert(rows.size(), '{rq(CMD_REMOVE, 0, 0, 0, 0, 0), 1,
                                   mk(KIND_REMOVE, 0, 0, 0, 0, 1)});
        rows.insert(rows.size(), '{rq(CMD_ADD, 5, 0, 0, 3, 0), 1,
                                   mk(KIND_ADD, 0, 0, 0, 0, 1)});
        rows.insert(rows.size(), '{rq(CMD_ADD, 0, 16'hffff, 0, 0, 0), 1,
                                   mk(KIND_ADD, 1, 0, 1, 0, 1)});
        rows.insert(rows.size(), '{rq(CMD_ADD, '1, 16'h0001, 1, '1, '1), 0,
                                   mk(KIND_ADD, 0, 0, 0, 0, 0)});
        rows.insert(rows.size(), '{rq(CMD_NONE, '1, '1, 1, '1, '1), 0,
                                   mk(KIND_ADD, 0, 0, 0, 0, 0)});
        for (int i = 0; i < 15; i++)
            rows.insert(rows.size(), '{rq(CMD_ADD, 10, 16'(100 + i), 1'(i % 2), 32'(i % 3), 0),
                                       0, mk(KIND_ADD, 0, 0, 0, 0, 0)});
        rows.insert(rows.size(), '{rq(CMD_ADD, 10, 7, 0, 1, 0), 1,
                                   mk(KIND_ADD, 0, 0, 0, 0, 1)});
        rows.insert(rows.size(), '{rq(CMD_TICK, 20, 0, 0, 0, 0), 0,
                                   mk(KIND_ADD, 0, 0, 0, 0, 0)});
        rows.insert(rows.size(), '{rq(CMD_REMOVE, 0, 0, 0, 0, 2), 1,
                                   mk(KIND_REMOVE, 0, 1, 1, 0, 1)});
        rows.insert(rows.size(), '{rq(CMD_REMOVE, 0, 0, 0, 0, '1), 1,
                                   mk(KIND_REMOVE, 0, 0, 0, 0, 1)});

        src_idle = 21; snk_idle = 55;
        foreach (rows[r]) begin
            if (rows[r].typed) begin
                wait_drain();
                send_request(rows[r].req);
                first_rep = pending_replies[0];
                if (!same_reply(first_rep, rows[r].rep)) begin
                    $error("row %0d: typed reply disagrees with predictor", r);
                    errors++;
                end
            end else begin
                send_request(rows[r].req);
            end
        end

        // pause the sender until the table has answered everything
        wait_drain();

        clock_now = 30;
        for (n_rand = 0; n_rand < 135; n_rand++) begin
            if (n_rand == 45) begin src_idle = 55; snk_idle = 21; end
            if (n_rand == 90) begin src_idle = 0;  snk_idle = 0;  end
            clock_now += $urandom_range(40);
            send_request(rand_req(clock_now));
        end
        wait_drain();
        repeat (300) @(negedge i_clk);

        $display("Sent %0d requests, checked %0d reply beats, %0d timers fired.",
                 n_sent, n_replies, n_fired);
        $display("Covered refusals, full table, saturation, ordering and three idle mixes.");
        if (errors == 0 && pending_replies.size() == 0)
            $display("oneshot_periodic_timer_table_tb passed");
        else
            $display("oneshot_periodic_timer_table_tb failed");
        $finish;
    end
endmodule
